[sv/xtc_pkg.sv]
// Package for the xor trie counting unit: field widths, item and status codes,
// walk pass codes and the command and status groups between controller and datapath.
// No dependencies.
package xtc_pkg;

  // Field widths of the input and result items.
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int LIMIT_W  = 32;
  localparam int MATCH_W  = 11;
  localparam int STATUS_W = 2;

  // Default sizes handed to the top level parameters.
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_MAX_NODES   = 16384;
  localparam int DEF_MAX_ENTRIES = 1024;

  // Largest reported match count.
  localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POOL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // Kind of walk through the trie.
  typedef enum logic [1:0] {
    PASS_VERIFY,
    PASS_INSERT,
    PASS_REMOVE,
    PASS_QUERY
  } pass_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;        // capture the item and start a walk at the root
    logic                restart;     // start a new walk at the root
    logic                step;        // follow one link, issue the node reads
    logic                load_node;   // take the child node as the current node
    logic                note_miss;   // record the nodes an insert has to add
    logic                write_leaf;  // write the leaf and update the entry total
    logic                emit;        // load the result register
    pass_t               pass;
    logic [STATUS_W-1:0] status;
  } xtc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              link_zero;   // the link to follow is empty
    logic              walk_end;    // a query reached an empty link
    logic              last_lvl;    // the walk is on the lowest key bit
    logic              total_full;  // the entry total is at its limit
    logic              pool_short;  // the missing nodes do not fit in the pool
    logic              leaf_zero;   // the current node count is zero
  } xtc_stat_t;

endpackage

[sv/xtc_if.sv]
// Channel interfaces of the xor trie counting unit: input items and results.
// Depends on xtc_pkg for the field widths.
interface xtc_in_if import xtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic [LIMIT_W-1:0] limit;

  modport source (output valid, output kind, output value, output limit, input ready);
  modport sink   (input valid, input kind, input value, input limit, output ready);
endinterface

interface xtc_out_if import xtc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MATCH_W-1:0]  match_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output match_count, output status, input ready);
  modport sink   (input valid, input match_count, input status, output ready);
endinterface

[sv/xtc_ctrl.sv]
// Controller of the xor trie counting unit: sequences the verify, update and
// query walks and owns the handshakes. Depends on xtc_pkg.
module xtc_ctrl import xtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  xtc_stat_t stat,
  output xtc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_LEAF  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  pass_t               pass_r, pass_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.pass      = pass_r;
    cmd.status    = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.kind)
          KIND_INSERT: begin
            if (stat.total_full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              pass_nxt  = PASS_VERIFY;
              state_nxt = S_STEP;
            end
          end
          KIND_REMOVE: begin
            pass_nxt  = PASS_VERIFY;
            state_nxt = S_STEP;
          end
          KIND_QUERY: begin
            pass_nxt  = PASS_QUERY;
            state_nxt = S_STEP;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_STEP: begin
        // A verify walk ends at the first empty link; other walks go on.
        if ((pass_r == PASS_VERIFY) && stat.link_zero) begin
          if (stat.kind == KIND_INSERT) begin
            cmd.note_miss = 1'b1;
            state_nxt     = S_CHECK;
          end else begin
            status_nxt = ST_ABSENT;
            state_nxt  = S_FIN;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_node = 1'b1;
        if (pass_r == PASS_QUERY) begin
          state_nxt = (stat.walk_end || stat.last_lvl) ? S_FIN : S_STEP;
        end else if (stat.last_lvl) begin
          state_nxt = (pass_r == PASS_VERIFY) ? S_CHECK : S_LEAF;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_CHECK: begin
        // Decide between rejecting the item and running the update walk.
        if (stat.kind == KIND_INSERT) begin
          if (stat.pool_short) begin
            status_nxt = ST_POOL;
            state_nxt  = S_FIN;
          end else begin
            cmd.restart = 1'b1;
            pass_nxt    = PASS_INSERT;
            state_nxt   = S_STEP;
          end
        end else begin
          if (stat.leaf_zero) begin
            status_nxt = ST_ABSENT;
            state_nxt  = S_FIN;
          end else begin
            cmd.restart = 1'b1;
            pass_nxt    = PASS_REMOVE;
            state_nxt   = S_STEP;
          end
        end
      end
      S_LEAF: begin
        cmd.write_leaf = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        // The result register takes the result once it is empty or draining.
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= PASS_VERIFY;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/xtc_dpath.sv]
// Datapath of the xor trie counting unit: node memory, root links, walk registers,
// pool and entry counters and the result register. Depends on xtc_pkg.
module xtc_dpath import xtc_pkg::*; #(
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  xtc_cmd_t            cmd,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [LIMIT_W-1:0]  in_limit,
  output xtc_stat_t           stat,
  output logic [MATCH_W-1:0]  out_match_count,
  output logic [STATUS_W-1:0] out_status
);

  localparam int LINK_W = $clog2(MAX_NODES);
  localparam int NF_W   = LINK_W + 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int NODE_W = 2 * LINK_W + CNT_W;
  localparam int LVL_W  = $clog2(KEY_BITS);
  localparam int NEED_W = $clog2(KEY_BITS + 1);
  localparam int PS_W   = NF_W + NEED_W;
  localparam int SUM_W  = (CNT_W > MATCH_W) ? CNT_W : MATCH_W;

  // Node memory: {link1, link0, count}; entry 0 stays unused, the root is in flops.
  logic [NODE_W-1:0] node_mem [MAX_NODES];
  logic [NODE_W-1:0] rd_a_r, rd_b_r;
  logic              wr_en;
  logic [LINK_W-1:0] wr_addr;
  logic [NODE_W-1:0] wr_data;

  logic [LINK_W-1:0]   root_l0_r, root_l1_r;
  logic [NF_W-1:0]     next_free_r;
  logic [CNT_W-1:0]    total_r;
  logic [KIND_W-1:0]   kind_r;
  logic [VALUE_W-1:0]  val_r;
  logic [KEY_BITS-1:0] key_sh_r, lim_sh_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [LINK_W-1:0]   cur_idx_r, cur_l0_r, cur_l1_r;
  logic [CNT_W-1:0]    cur_cnt_r;
  logic [LINK_W-1:0]   nx_r;
  logic                alloc_r, add_r, end_r;
  logic [NEED_W-1:0]   need_r;
  logic [SUM_W-1:0]    sum_r;
  logic [MATCH_W-1:0]  out_match_count_r;
  logic [STATUS_W-1:0] out_status_r;

  logic              kb, lb, fb;
  logic [LINK_W-1:0] link_f, link_s, nx_new, upd_l0, upd_l1;
  logic              alloc, upd_pass;
  logic [CNT_W-1:0]  rd_cnt, ld_cnt;

  // Link selection for the current key bit.
  always_comb begin
    kb       = key_sh_r[KEY_BITS-1];
    lb       = lim_sh_r[KEY_BITS-1];
    // A query with the limit bit set moves to the xor-1 child.
    fb       = (cmd.pass == PASS_QUERY) ? (kb ^ lb) : kb;
    link_f   = fb ? cur_l1_r : cur_l0_r;
    link_s   = kb ? cur_l1_r : cur_l0_r;
    alloc    = (cmd.pass == PASS_INSERT) && (link_f == '0);
    nx_new   = alloc ? next_free_r[LINK_W-1:0] : link_f;
    upd_pass = (cmd.pass == PASS_INSERT) || (cmd.pass == PASS_REMOVE);
    upd_l0   = cur_l0_r;
    upd_l1   = cur_l1_r;
    if (fb) begin
      upd_l1 = nx_new;
    end else begin
      upd_l0 = nx_new;
    end
  end

  // Write port: the current node on leaving it, or the leaf at the end.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx_r;
    wr_data = {cur_l1_r, cur_l0_r, cur_cnt_r};
    if (cmd.step && upd_pass && (cur_idx_r != '0)) begin
      wr_en   = 1'b1;
      wr_data = {upd_l1, upd_l0, cur_cnt_r};
    end
    if (cmd.write_leaf) begin
      wr_en = 1'b1;
    end
  end

  // Count of the child that was read, adjusted by the update walk.
  always_comb begin
    rd_cnt = rd_a_r[CNT_W-1:0];
    unique case (cmd.pass)
      PASS_INSERT: ld_cnt = rd_cnt + CNT_W'(1);
      PASS_REMOVE: ld_cnt = rd_cnt - CNT_W'(1);
      default:     ld_cnt = rd_cnt;
    endcase
  end

  // Node memory with two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (cmd.step) begin
      rd_a_r <= node_mem[link_f];
      rd_b_r <= node_mem[link_s];
    end
  end

  // Root links, pool pointer and entry total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_l0_r   <= '0;
      root_l1_r   <= '0;
      next_free_r <= NF_W'(1);
      total_r     <= '0;
    end else begin
      if (cmd.step && (cmd.pass == PASS_INSERT) && (cur_idx_r == '0)) begin
        root_l0_r <= upd_l0;
        root_l1_r <= upd_l1;
      end
      if (cmd.step && alloc) begin
        next_free_r <= next_free_r + NF_W'(1);
      end
      if (cmd.write_leaf) begin
        if (cmd.pass == PASS_INSERT) begin
          total_r <= total_r + CNT_W'(1);
        end else if (total_r != '0) begin
          total_r <= total_r - CNT_W'(1);
        end
      end
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      val_r    <= in_value;
      lim_sh_r <= KEY_BITS'(in_limit);
      sum_r    <= '0;
      need_r   <= '0;
    end
    if (cmd.load || cmd.restart) begin
      key_sh_r  <= cmd.load ? KEY_BITS'(in_value) : KEY_BITS'(val_r);
      lvl_r     <= LVL_W'(KEY_BITS - 1);
      cur_idx_r <= '0;
      cur_l0_r  <= root_l0_r;
      cur_l1_r  <= root_l1_r;
      cur_cnt_r <= '0;
    end
    if (cmd.note_miss) begin
      need_r <= NEED_W'(lvl_r) + NEED_W'(1);
    end
    if (cmd.step) begin
      nx_r    <= nx_new;
      alloc_r <= alloc;
      add_r   <= (cmd.pass == PASS_QUERY) && lb && (link_s != '0);
      end_r   <= (link_f == '0);
    end
    if (cmd.load_node) begin
      cur_idx_r <= nx_r;
      if (alloc_r) begin
        cur_l0_r  <= '0;
        cur_l1_r  <= '0;
        cur_cnt_r <= CNT_W'(1);
      end else begin
        cur_l0_r  <= rd_a_r[CNT_W +: LINK_W];
        cur_l1_r  <= rd_a_r[CNT_W + LINK_W +: LINK_W];
        cur_cnt_r <= ld_cnt;
      end
      if (add_r) begin
        sum_r <= sum_r + SUM_W'(rd_b_r[CNT_W-1:0]);
      end
      key_sh_r <= key_sh_r << 1;
      lim_sh_r <= lim_sh_r << 1;
      lvl_r    <= lvl_r - LVL_W'(1);
    end
  end

  // Result register; the sum stays zero for items other than queries.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_match_count_r <= (sum_r > SUM_W'(MATCH_MAX)) ? MATCH_MAX : sum_r[MATCH_W-1:0];
      out_status_r      <= cmd.status;
    end
  end

  assign out_match_count = out_match_count_r;
  assign out_status      = out_status_r;

  // Status toward the controller.
  always_comb begin
    stat            = '0;
    stat.kind       = kind_r;
    stat.link_zero  = (link_f == '0);
    stat.walk_end   = end_r;
    stat.last_lvl   = (lvl_r == '0);
    stat.total_full = (total_r >= CNT_W'(MAX_ENTRIES));
    stat.pool_short = (PS_W'(next_free_r) + PS_W'(need_r)) > PS_W'(MAX_NODES);
    stat.leaf_zero  = (cur_cnt_r == '0);
  end

endmodule

[sv/xor_trie_count_below_limit_unit.sv]
// Top level of the xor trie counting unit: joins controller and datapath to the channels.
// Depends on xtc_pkg, xtc_if, xtc_ctrl and xtc_dpath.
//
//   channel   direction  handshake      payload
//   in_chan   input      valid / ready  kind, value, limit
//   out_chan  output     valid / ready  match_count, status
//
// Each trie level first issues the node memory read (S_STEP in the controller), then
// takes the registered read data (S_LOAD). A query runs a single walk; an insert or a
// remove runs a verify walk, then an update walk. Rejected items end early. One item is
// worked on at a time; the next one is taken while the previous result waits in the
// result register.
// Reset is synchronous; the root links sit in flops, so no memory clearing is needed.
// A stalled result holds the block only once the next result is ready to leave.
module xor_trie_count_below_limit_unit import xtc_pkg::*; #(
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input logic       clk,
  input logic       rst_n,
  xtc_in_if.sink    in_chan,
  xtc_out_if.source out_chan
);

  xtc_cmd_t  cmd;
  xtc_stat_t stat;

  // Sequencing and handshakes.
  xtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Trie storage and walk.
  xtc_dpath #(
    .KEY_BITS    (KEY_BITS),
    .MAX_NODES   (MAX_NODES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_chan.kind),
    .in_value        (in_chan.value),
    .in_limit        (in_chan.limit),
    .stat            (stat),
    .out_match_count (out_chan.match_count),
    .out_status      (out_chan.status)
  );

  // The result register is loaded only when it is free or draining.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten");

  // After an input transfer the block is busy in the following cycle.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while an item is in work");

  // A new result appears only after the controller loaded it.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.emit))
    else $error("result valid without a load");

  // The leaf is written only at the end of an update walk.
  a_leaf_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_leaf |-> (cmd.pass == PASS_INSERT || cmd.pass == PASS_REMOVE))
    else $error("leaf write outside an update walk");

endmodule
